>>> sv/chol_pkg.sv
package chol_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int IDX_W     = 4;
    localparam int FRAC_W    = 28;
    localparam int DIV_STEPS = ACC_W + FRAC_W;
    localparam int DCNT_W    = 7;
    localparam int SQ_STEPS  = 32;

    localparam logic [DATA_W-1:0] Q_ONE  = 32'h1000_0000;
    localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;

    localparam logic [IDX_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_DOT_RD,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_RES_RD,
        ST_RES,
        ST_SQRT,
        ST_DIV,
        ST_NEXT,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

>>> sv/cholesky_factorizer.sv
// Loading: one matrix entry per cycle, n*n transactions per matrix with n = dim clamped to 1..MAX_DIM.
// Factorization starts on the last entry: each element is sequenced and its dot product
// accumulated, then a diagonal takes a radix-4 root and an off-diagonal entry the
// bit-serial divider, skipped on a failed pivot or a saturated diagonal; results then leave one by one.
// Both matrix and factor live in registered-read memories with no reset;
// synchronous active-low reset clears sequencer, load count, error flag and output valid, sets dim to 8.
module cholesky_factorizer #(
    parameter int MAX_DIM = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [chol_pkg::IDX_W-1:0]         cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [chol_pkg::DATA_W-1:0] s_matrix_entry,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [chol_pkg::DATA_W-1:0] m_factor_entry,
    output logic                               m_last_of_run,
    output logic                               m_pivot_error
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = chol_pkg::DATA_W;
    localparam int SW    = chol_pkg::ACC_W;
    localparam int IW    = chol_pkg::IDX_W;
    localparam int NW    = chol_pkg::DIV_STEPS;

    logic [DW-1:0] matrix_mem [DEPTH];
    logic [DW-1:0] factor_mem [DEPTH];

    chol_pkg::state_t state_reg, state_next;
    logic [IW-1:0] dim_reg, dim_next;
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic          err_reg, err_next;
    logic          m_valid_reg, m_valid_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;

    logic signed [SW-1:0] acc_reg, acc_next;
    logic signed [SW-1:0] prod_reg, prod_next;
    logic [SW-1:0]        sq_x_reg, sq_x_next, sq_res_reg, sq_res_next, sq_bit_reg, sq_bit_next;
    logic [NW-1:0]        dv_n_reg, dv_n_next;
    logic [DW:0]          dv_rem_reg, dv_rem_next;
    logic [NW-1:0]        dv_q_reg, dv_q_next;
    logic [DW-1:0]        dv_d_reg, dv_d_next;
    logic                 dv_neg_reg, dv_neg_next;
    logic [chol_pkg::DCNT_W-1:0] dv_cnt_reg, dv_cnt_next;

    logic [DW-1:0] out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_err_reg, out_err_next;

    logic [DW-1:0] mat_rd_reg, fac_rda_reg, fac_rdb_reg;
    logic [AW-1:0] addr_a, addr_b, addr_m;
    logic          fac_we;
    logic [DW-1:0] fac_wdata;

    logic [IW-1:0] n_eff;
    logic [CW-1:0] total;

    logic signed [SW-1:0] resid, rnd;
    logic [SW-1:0]        sq_t, mag;
    logic [DW:0]          dv_rs;

    function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                              input logic [IW-1:0] n);
        logic [2*IW:0] t;
        t = (2*IW+1)'(r) * (2*IW+1)'(n) + (2*IW+1)'(c);
        return t[AW-1:0];
    endfunction

    always_comb begin
        if (dim_reg == '0) begin
            n_eff = IW'(1);
        end else if (dim_reg > IW'(MAX_DIM)) begin
            n_eff = IW'(MAX_DIM);
        end else begin
            n_eff = dim_reg;
        end
    end

    assign total = CW'(n_eff) * CW'(n_eff);

    assign s_ready        = (state_reg == chol_pkg::ST_LOAD);
    assign m_valid        = m_valid_reg;
    assign m_factor_entry = out_data_reg;
    assign m_last_of_run  = out_last_reg;
    assign m_pivot_error  = out_err_reg;

    assign addr_b = addr_of(j_reg, k_reg, n_eff);
    assign addr_m = addr_of(i_reg, j_reg, n_eff);

    always_comb begin
        case (state_reg)
            chol_pkg::ST_DOT_RD: addr_a = addr_of(i_reg, k_reg, n_eff);
            chol_pkg::ST_RES_RD: addr_a = addr_of(j_reg, j_reg, n_eff);
            default:             addr_a = addr_of(i_reg, j_reg, n_eff);
        endcase
    end

    assign resid = SW'($signed(mat_rd_reg)) - acc_reg;
    assign mag   = resid[SW-1] ? (SW'(0) - SW'(resid)) : SW'(resid);
    assign rnd   = (prod_reg + SW'(64'sd1 <<< (chol_pkg::FRAC_W - 1))) >>> chol_pkg::FRAC_W;
    assign sq_t  = sq_res_reg + sq_bit_reg;
    assign dv_rs = {dv_rem_reg[DW-1:0], dv_n_reg[NW-1]};

    always_comb begin
        state_next    = state_reg;
        dim_next      = dim_reg;
        load_cnt_next = load_cnt_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        sq_x_next     = sq_x_reg;
        sq_res_next   = sq_res_reg;
        sq_bit_next   = sq_bit_reg;
        dv_n_next     = dv_n_reg;
        dv_rem_next   = dv_rem_reg;
        dv_q_next     = dv_q_reg;
        dv_d_next     = dv_d_reg;
        dv_neg_next   = dv_neg_reg;
        dv_cnt_next   = dv_cnt_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        out_err_next  = out_err_reg;
        fac_we        = 1'b0;
        fac_wdata     = chol_pkg::Q_ZERO;

        case (state_reg)
            chol_pkg::ST_LOAD: begin
                if (s_valid) begin
                    if (load_cnt_reg + CW'(1) >= total) begin
                        load_cnt_next = '0;
                        err_next      = 1'b0;
                        i_next        = '0;
                        j_next        = '0;
                        state_next    = chol_pkg::ST_INIT;
                    end else begin
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                end
            end
            chol_pkg::ST_INIT: begin
                acc_next   = '0;
                k_next     = '0;
                state_next = (j_reg == '0) ? chol_pkg::ST_RES_RD : chol_pkg::ST_DOT_RD;
            end
            chol_pkg::ST_DOT_RD: begin
                state_next = chol_pkg::ST_DOT_MUL;
            end
            chol_pkg::ST_DOT_MUL: begin
                prod_next  = $signed(fac_rda_reg) * $signed(fac_rdb_reg);
                state_next = chol_pkg::ST_DOT_ACC;
            end
            chol_pkg::ST_DOT_ACC: begin
                acc_next   = acc_reg + rnd;
                k_next     = k_reg + IW'(1);
                state_next = (k_reg + IW'(1) == j_reg) ? chol_pkg::ST_RES_RD
                                                        : chol_pkg::ST_DOT_RD;
            end
            chol_pkg::ST_RES_RD: begin
                state_next = chol_pkg::ST_RES;
            end
            chol_pkg::ST_RES: begin
                if (i_reg == j_reg) begin
                    if (resid <= 0) begin
                        err_next   = 1'b1;
                        fac_we     = 1'b1;
                        fac_wdata  = chol_pkg::Q_ZERO;
                        state_next = chol_pkg::ST_NEXT;
                    end else if (resid >= (64'sd1 <<< 34)) begin
                        fac_we     = 1'b1;
                        fac_wdata  = chol_pkg::Q_MAX;
                        state_next = chol_pkg::ST_NEXT;
                    end else begin
                        sq_x_next   = SW'(resid) << chol_pkg::FRAC_W;
                        sq_res_next = '0;
                        sq_bit_next = SW'(1) << 62;
                        state_next  = chol_pkg::ST_SQRT;
                    end
                end else if ($signed(fac_rda_reg) <= 0) begin
                    // failed pivot: division yields zero
                    fac_we     = 1'b1;
                    fac_wdata  = chol_pkg::Q_ZERO;
                    state_next = chol_pkg::ST_NEXT;
                end else begin
                    dv_n_next   = {mag, chol_pkg::FRAC_W'(0)};
                    dv_rem_next = '0;
                    dv_q_next   = '0;
                    dv_d_next   = fac_rda_reg;
                    dv_neg_next = resid[SW-1];
                    dv_cnt_next = '0;
                    state_next  = chol_pkg::ST_DIV;
                end
            end
            chol_pkg::ST_SQRT: begin
                if (sq_x_reg >= sq_t) begin
                    sq_x_next   = sq_x_reg - sq_t;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0]) begin
                    fac_we     = 1'b1;
                    fac_wdata  = sq_res_next[DW-1:0];
                    state_next = chol_pkg::ST_NEXT;
                end
            end
            chol_pkg::ST_DIV: begin
                dv_n_next = dv_n_reg << 1;
                if (dv_rs >= {1'b0, dv_d_reg}) begin
                    dv_rem_next = dv_rs - {1'b0, dv_d_reg};
                    dv_q_next   = {dv_q_reg[NW-2:0], 1'b1};
                end else begin
                    dv_rem_next = dv_rs;
                    dv_q_next   = {dv_q_reg[NW-2:0], 1'b0};
                end
                dv_cnt_next = dv_cnt_reg + chol_pkg::DCNT_W'(1);
                if (dv_cnt_reg == chol_pkg::DCNT_W'(NW - 1)) begin
                    fac_we = 1'b1;
                    if (dv_neg_reg) begin
                        fac_wdata = (dv_q_next >= NW'(64'h8000_0000)) ? chol_pkg::Q_MIN
                                  : chol_pkg::Q_ZERO - dv_q_next[DW-1:0];
                    end else begin
                        fac_wdata = (dv_q_next > NW'(64'h7FFF_FFFF)) ? chol_pkg::Q_MAX
                                  : dv_q_next[DW-1:0];
                    end
                    state_next = chol_pkg::ST_NEXT;
                end
            end
            chol_pkg::ST_NEXT: begin
                state_next = chol_pkg::ST_INIT;
                if (j_reg == i_reg) begin
                    j_next = '0;
                    if (i_reg == n_eff - IW'(1)) begin
                        i_next     = '0;
                        state_next = chol_pkg::ST_OUT_RD;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            chol_pkg::ST_OUT_RD: begin
                // hold until the output register is free
                if (!m_valid_reg) begin
                    state_next = chol_pkg::ST_OUT_LD;
                end
            end
            chol_pkg::ST_OUT_LD: begin
                m_valid_next = 1'b1;
                if (err_reg) begin
                    out_data_next = (i_reg == j_reg) ? chol_pkg::Q_ONE : chol_pkg::Q_ZERO;
                end else begin
                    out_data_next = fac_rda_reg;
                end
                out_last_next = (i_reg == n_eff - IW'(1)) && (j_reg == i_reg);
                out_err_next  = err_reg;
                state_next    = chol_pkg::ST_OUT_RD;
                if (j_reg == i_reg) begin
                    j_next = '0;
                    if (i_reg == n_eff - IW'(1)) begin
                        i_next     = '0;
                        state_next = chol_pkg::ST_LOAD;
                    end else begin
                        i_next = i_reg + IW'(1);
                    end
                end else begin
                    j_next = j_reg + IW'(1);
                end
            end
            default: begin
                state_next = chol_pkg::ST_LOAD;
            end
        endcase

        if (cfg_we) begin
            dim_next      = cfg_wdata;
            load_cnt_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= chol_pkg::ST_LOAD;
            dim_reg      <= chol_pkg::DIM_RESET;
            load_cnt_reg <= '0;
            err_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dim_reg      <= dim_next;
            load_cnt_reg <= load_cnt_next;
            err_reg      <= err_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        sq_x_reg     <= sq_x_next;
        sq_res_reg   <= sq_res_next;
        sq_bit_reg   <= sq_bit_next;
        dv_n_reg     <= dv_n_next;
        dv_rem_reg   <= dv_rem_next;
        dv_q_reg     <= dv_q_next;
        dv_d_reg     <= dv_d_next;
        dv_neg_reg   <= dv_neg_next;
        dv_cnt_reg   <= dv_cnt_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            matrix_mem[load_cnt_reg[AW-1:0]] <= s_matrix_entry;
        end
        mat_rd_reg <= matrix_mem[addr_m];
    end

    always_ff @(posedge aclk) begin
        if (fac_we) begin
            factor_mem[addr_m] <= fac_wdata;
        end
        fac_rda_reg <= factor_mem[addr_a];
        fac_rdb_reg <= factor_mem[addr_b];
    end

endmodule

>>> sv/chol_checker.sv
module chol_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [chol_pkg::DATA_W-1:0] m_factor_entry,
    input logic                               m_last_of_run,
    input logic                               m_pivot_error
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_factor_entry)
            && $stable(m_last_of_run) && $stable(m_pivot_error))
        else $error("stalled result changed");

    // identity output on pivot failure
    a_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pivot_error |->
            (m_factor_entry == chol_pkg::Q_ONE) || (m_factor_entry == chol_pkg::Q_ZERO))
        else $error("pivot error with non-identity entry");

    // no input taken in the middle of a result run
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> !s_ready)
        else $error("input ready during result run");

endmodule

bind cholesky_factorizer chol_checker u_chol_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_factor_entry (m_factor_entry),
    .m_last_of_run  (m_last_of_run),
    .m_pivot_error  (m_pivot_error)
);

>>> dv/cholesky_factorizer_tb.sv
module cholesky_factorizer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 10;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic signed [chol_pkg::DATA_W-1:0] entry;
        logic                               last;
        logic                               err;
    } factor_item_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               cfg_we;
    logic [chol_pkg::IDX_W-1:0]         cfg_wdata;
    logic                               s_valid;
    logic                               s_ready;
    logic signed [chol_pkg::DATA_W-1:0] s_matrix_entry;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [chol_pkg::DATA_W-1:0] m_factor_entry;
    logic                               m_last_of_run;
    logic                               m_pivot_error;

    factor_item_t    factor_queue[$];
    int              error_count;
    bit              send_gaps;
    bit              recv_gaps;
    int              hold_off;

    // predictor state
    logic signed [chol_pkg::DATA_W-1:0] mat_copy[100];
    logic signed [chol_pkg::DATA_W-1:0] fac_copy[100];
    int unsigned                        entries_loaded;
    logic [chol_pkg::IDX_W-1:0]         dim_reg;

    cholesky_factorizer #(.MAX_DIM(MAX_DIM)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_matrix_entry (s_matrix_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_factor_entry (m_factor_entry),
        .m_last_of_run  (m_last_of_run),
        .m_pivot_error  (m_pivot_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned active_dim();
        if (dim_reg == 0) return 1;
        if (dim_reg > MAX_DIM) return MAX_DIM;
        return dim_reg;
    endfunction

    function automatic logic signed [63:0] round_product(
        logic signed [chol_pkg::DATA_W-1:0] a,
        logic signed [chol_pkg::DATA_W-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return (p + 64'sd134217728) >>> chol_pkg::FRAC_W;
    endfunction

    function automatic logic [chol_pkg::DATA_W-1:0] root_q28(logic [63:0] r);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x = r << chol_pkg::FRAC_W;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[chol_pkg::DATA_W-1:0];
    endfunction

    function automatic logic signed [chol_pkg::DATA_W-1:0] divide_q28(
        logic signed [63:0] r,
        logic signed [chol_pkg::DATA_W-1:0] d);
        logic [127:0] mag;
        logic [127:0] q;
        if (d <= 0) return 0;
        mag = (r < 0) ? 128'(-r) : 128'(r);
        q = (mag << chol_pkg::FRAC_W) / 128'(d);
        if (r < 0)
            return (q >= 128'h8000_0000) ? chol_pkg::Q_MIN
                                         : -$signed(q[chol_pkg::DATA_W-1:0]);
        return (q > 128'h7FFF_FFFF) ? chol_pkg::Q_MAX : q[chol_pkg::DATA_W-1:0];
    endfunction

    // factor the loaded matrix and queue the lower triangle
    task automatic predict_factor(int unsigned n);
        logic signed [63:0] acc;
        logic signed [63:0] resid;
        bit                 bad;
        factor_item_t       it;
        int unsigned        total;
        int unsigned        cnt;
        bad = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j <= i; j++) begin
                acc = 0;
                for (int k = 0; k < j; k++)
                    acc += round_product(fac_copy[i*n+k], fac_copy[j*n+k]);
                resid = 64'(mat_copy[i*n+j]) - acc;
                if (i == j) begin
                    if (resid <= 0) begin
                        bad = 1;
                        fac_copy[i*n+i] = 0;
                    end else if (resid >= (64'sd1 << 34)) begin
                        fac_copy[i*n+i] = chol_pkg::Q_MAX;
                    end else begin
                        fac_copy[i*n+i] = root_q28(resid);
                    end
                end else begin
                    fac_copy[i*n+j] = divide_q28(resid, fac_copy[j*n+j]);
                end
            end
        end
        total = n * (n + 1) / 2;
        cnt = 0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j <= i; j++) begin
                cnt++;
                it.entry = bad ? ((i == j) ? chol_pkg::Q_ONE : chol_pkg::Q_ZERO)
                               : fac_copy[i*n+j];
                it.last  = (cnt == total);
                it.err   = bad;
                factor_queue.push_back(it);
            end
        end
    endtask

    task automatic send_entry(logic signed [chol_pkg::DATA_W-1:0] v);
        int unsigned n;
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_matrix_entry <= v;
        do @(posedge aclk); while (!s_ready);
        n = active_dim();
        mat_copy[entries_loaded] = v;
        entries_loaded++;
        if (entries_loaded == n * n) begin
            entries_loaded = 0;
            predict_factor(n);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (factor_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_dim(logic [chol_pkg::IDX_W-1:0] d);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        dim_reg = d;
        entries_loaded = 0;
    endtask

    function automatic logic signed [chol_pkg::DATA_W-1:0] rand_word();
        return $signed($urandom());
    endfunction

    // symmetric positive definite: A = B*B' + I, small B entries
    task automatic send_spd(int unsigned n, int unsigned scale);
        logic signed [chol_pkg::DATA_W-1:0] b[100];
        logic signed [63:0]                 s;
        for (int i = 0; i < n * n; i++)
            b[i] = $signed(32'($urandom_range(0, 2 * scale)) - 32'(scale));
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                s = 0;
                for (int k = 0; k < n; k++)
                    s += round_product(b[i*n+k], b[j*n+k]);
                if (i == j) s += 64'sd268435456;
                send_entry(s[chol_pkg::DATA_W-1:0]);
            end
        end
    endtask

    task automatic test_directed_extremes();
        write_dim(4'd1);
        send_entry(chol_pkg::Q_ONE);
        send_entry(chol_pkg::Q_MAX);
        send_entry(chol_pkg::Q_MIN);
        send_entry(chol_pkg::Q_ZERO);
        send_entry(32'sd1);
        write_dim(4'd2);
        // 2x2 with a saturating divide and a negative off-diagonal
        send_entry(32'sd4);            send_entry(chol_pkg::Q_MIN);
        send_entry(chol_pkg::Q_MAX);   send_entry(chol_pkg::Q_MAX);
        send_entry(chol_pkg::Q_ONE);   send_entry(32'h7000_0000);
        send_entry(32'h9000_0000);     send_entry(chol_pkg::Q_ONE);
        // second pivot fails
        send_entry(chol_pkg::Q_ONE);   send_entry(32'h1234_5678);
        send_entry(chol_pkg::Q_ONE);   send_entry(chol_pkg::Q_ONE);
        write_dim(4'd0);
        send_entry(32'h4000_0000);
        write_dim(4'd15);
        send_spd(MAX_DIM, 32'h0100_0000);
    endtask

    task automatic test_partial_load_drop();
        write_dim(4'd3);
        repeat (4) send_entry(rand_word());
        write_dim(4'd3);
        send_spd(3, 32'h0800_0000);
    endtask

    task automatic test_random_matrices();
        int unsigned n;
        int unsigned sent;
        sent = 0;
        while (sent < 270) begin
            write_dim(4'($urandom_range(0, 15)));
            n = active_dim();
            if (n > 5 && $urandom_range(0, 3) != 0) begin
                write_dim(4'($urandom_range(1, 4)));
                n = active_dim();
            end
            if ($urandom_range(0, 4) == 0)
                repeat (n * n) send_entry(rand_word());
            else
                send_spd(n, $urandom_range(1, 32'h1000_0000));
            sent += n * n;
        end
    endtask

    task automatic test_backpressure();
        write_dim(4'd4);
        hold_off = 3000;
        send_spd(4, 32'h0400_0000);
        send_spd(4, 32'h0400_0000);
        wait_idle();
    endtask

    task automatic test_no_gaps();
        send_gaps = 0;
        recv_gaps = 0;
        write_dim(4'd3);
        repeat (3) send_spd(3, 32'h0200_0000);
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        factor_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (factor_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_factor_entry);
                error_count++;
            end else begin
                exp_item = factor_queue.pop_front();
                if (m_factor_entry !== exp_item.entry) begin
                    $display("%0t: factor_entry expected %h actual %h",
                             $time, exp_item.entry, m_factor_entry);
                    error_count++;
                end
                if (m_last_of_run !== exp_item.last) begin
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, exp_item.last, m_last_of_run);
                    error_count++;
                end
                if (m_pivot_error !== exp_item.err) begin
                    $display("%0t: pivot_error expected %b actual %b",
                             $time, exp_item.err, m_pivot_error);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 10);
                m_ready <= 1'b0;
                repeat (gap - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_matrix_entry = '0;
        error_count    = 0;
        hold_off       = 0;
        send_gaps      = 1;
        recv_gaps      = 1;
        dim_reg        = chol_pkg::DIM_RESET;
        entries_loaded = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_partial_load_drop();
        test_random_matrices();
        test_backpressure();
        test_no_gaps();
        wait_idle();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
